@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define DAT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock clk_i and reset rst_ni.
`define DAT_ASSERT(lbl, prop, msg) \
  `DAT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ hw/rtl/dat_pkg.sv @@
// Types, constants and the digit split function of the telemetry framer.
`timescale 1ns / 1ps
package dat_pkg;

  localparam int unsigned DAT_VAL_W    = 17;
  localparam int unsigned DAT_LANES    = 3;
  localparam int unsigned DAT_DIGITS   = 5;
  localparam int unsigned DAT_CNT_W    = 4;

  localparam logic [DAT_VAL_W-1:0] DAT_VALUE_MAX = 17'd99999;
  localparam logic [7:0]           DAT_ASCII_ZERO = 8'h30;
  localparam logic [7:0]           DAT_ASCII_NINE = 8'h39;
  localparam logic [7:0]           DAT_TERMINATOR = 8'h0A;
  localparam logic [DAT_CNT_W-1:0] DAT_LAST_IDX   = 4'd15;

  // Place weights of the digit stages, index 0 is the ten-thousands place.
  localparam logic [3:0][DAT_VAL_W-1:0] DAT_WEIGHT =
    {17'd10, 17'd100, 17'd1000, 17'd10000};

  typedef logic [DAT_LANES-1:0][DAT_VAL_W-1:0]  dat_vals_t;
  typedef logic [DAT_LANES-1:0][DAT_DIGITS-1:0][3:0] dat_digits_t;

  typedef struct packed {
    logic        vld;
    dat_digits_t digits;
  } dat_frame_t;

  typedef struct packed {
    logic [3:0]           digit;
    logic [DAT_VAL_W-1:0] rem;
  } dat_split_t;

  // One decimal digit by compare and subtract; val must stay below 10 * weight.
  function automatic dat_split_t dat_digit_split(input logic [DAT_VAL_W-1:0] val,
                                                 input logic [DAT_VAL_W-1:0] weight);
    dat_split_t           res;
    logic [DAT_VAL_W-1:0] thr;
    res.digit = 4'd0;
    res.rem   = val;
    for (int k = 1; k < 10; k++) begin
      thr = DAT_VAL_W'(weight * DAT_VAL_W'(k));
      if (val >= thr) begin
        res.digit = 4'(k);
        res.rem   = val - thr;
      end
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/dat_digit_pipe.sv @@
// Pipelined binary to decimal digit conversion, three lanes side by side.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dat_digit_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  dat_pkg::dat_vals_t values_i,
  output logic               busy_o,
  input  logic               take_i,
  output dat_pkg::dat_frame_t frame_o
);
  import dat_pkg::*;

  // Stage 0 clamps, stages 1..4 each resolve one place, and stage 4 also the units.
  localparam int unsigned NSTG = DAT_DIGITS;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] free_w;
  dat_vals_t       rem_q [NSTG];
  dat_digits_t     dig_q [NSTG];
  dat_vals_t       rem_d [NSTG];
  dat_digits_t     dig_d [NSTG];
  logic            accept;

  // A stage may load when empty or when its content moves on.
  always_comb begin
    free_w[NSTG-1] = !vld_q[NSTG-1] || take_i;
    for (int s = NSTG - 2; s >= 0; s--) begin
      free_w[s] = !vld_q[s] || free_w[s+1];
    end
  end

  assign busy_o = !free_w[0];
  assign accept = start_i && free_w[0];

  always_comb begin
    dat_split_t sp;
    sp = '0;
    for (int l = 0; l < DAT_LANES; l++) begin
      rem_d[0][l] = (values_i[l] > DAT_VALUE_MAX) ? DAT_VALUE_MAX : values_i[l];
    end
    dig_d[0] = '0;
    for (int s = 1; s < NSTG; s++) begin
      dig_d[s] = dig_q[s-1];
      for (int l = 0; l < DAT_LANES; l++) begin
        sp = dat_digit_split(rem_q[s-1][l], DAT_WEIGHT[s-1]);
        rem_d[s][l]      = sp.rem;
        dig_d[s][l][s-1] = sp.digit;
        if (s == NSTG - 1) begin
          dig_d[s][l][DAT_DIGITS-1] = sp.rem[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (free_w[0]) begin
        vld_q[0] <= start_i;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (free_w[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rem_q[0] <= rem_d[0];
      dig_q[0] <= dig_d[0];
    end
    for (int s = 1; s < NSTG; s++) begin
      if (free_w[s] && vld_q[s-1]) begin
        rem_q[s] <= rem_d[s];
        dig_q[s] <= dig_d[s];
      end
    end
  end

  assign frame_o.vld    = vld_q[NSTG-1];
  assign frame_o.digits = dig_q[NSTG-1];

  // A finished transaction that is not taken holds its digits.
  `DAT_ASSERT(a_hold_on_stall,
    frame_o.vld && !take_i |=> frame_o.vld && $stable(frame_o.digits),
    "digit pipe lost or changed a stalled result")
  // Nothing enters while the first stage is blocked.
  `DAT_ASSERT(a_busy_blocks,
    busy_o |-> vld_q[0],
    "busy raised with an empty input stage")

endmodule

@@ hw/rtl/decimal_ascii_telemetry_framer_unit.sv @@
// Top level of the decimal ASCII telemetry framer.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  input    | start_i, busy_o           | voltage_value_i, current_value_i,
//           |                           | setpoint_value_i (17 bits each)
//  output   | frame_strobe_o            | frame_byte_o (8 bits), frame_last_o
//
//  Each transaction yields 16 bytes, one per cycle; the byte serializer sets the
//  sustained transaction rate.
//  After the accepting edge a transaction passes the five digit stages, then the serializer register, when it is free.
//  The five-stage digit pipe buffers up to five transactions behind the one
//  being serialized; busy_o rises only when all of them are full.
//  Reset clears valid bits and the serializer; the receiver cannot stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module decimal_ascii_telemetry_framer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [dat_pkg::DAT_VAL_W-1:0] voltage_value_i,
  input  logic [dat_pkg::DAT_VAL_W-1:0] current_value_i,
  input  logic [dat_pkg::DAT_VAL_W-1:0] setpoint_value_i,
  output logic                         frame_strobe_o,
  output logic [7:0]                   frame_byte_o,
  output logic                         frame_last_o
);
  import dat_pkg::*;

  dat_vals_t                  values;
  dat_frame_t                 pipe_frame;
  logic                       take;
  logic                       act_q, act_d;
  logic [DAT_CNT_W-1:0]       cnt_q, cnt_d;
  dat_digits_t                frame_q;
  logic [DAT_LANES*DAT_DIGITS-1:0][3:0] flat;
  logic                       is_last;

  assign values[0] = voltage_value_i;
  assign values[1] = current_value_i;
  assign values[2] = setpoint_value_i;

  dat_digit_pipe u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .values_i (values),
    .busy_o   (busy_o),
    .take_i   (take),
    .frame_o  (pipe_frame)
  );

  assign is_last = (cnt_q == DAT_LAST_IDX);
  // Serializer reloads on the terminator cycle so frames run back to back.
  assign take    = !act_q || is_last;

  always_comb begin
    act_d = act_q;
    cnt_d = cnt_q;
    if (take) begin
      act_d = pipe_frame.vld;
      cnt_d = '0;
    end else begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      act_q <= act_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pipe_frame.vld) begin
      frame_q <= pipe_frame.digits;
    end
  end

  assign flat = frame_q;

  always_comb begin
    if (is_last) begin
      frame_byte_o = DAT_TERMINATOR;
    end else begin
      frame_byte_o = DAT_ASCII_ZERO + {4'b0000, flat[cnt_q]};
    end
  end

  assign frame_strobe_o = act_q;
  assign frame_last_o   = act_q && is_last;

  // A frame runs without gaps up to its terminator.
  `DAT_ASSERT(a_frame_contiguous,
    frame_strobe_o && !frame_last_o |=> frame_strobe_o && !$stable(cnt_q),
    "frame interrupted before terminator")
  // Digit bytes stay within the ASCII digit range.
  `DAT_ASSERT(a_digit_range,
    frame_strobe_o && !frame_last_o |->
      frame_byte_o >= DAT_ASCII_ZERO && frame_byte_o <= DAT_ASCII_NINE,
    "non-digit byte inside frame")
  // A new frame starts at byte zero.
  `DAT_ASSERT(a_frame_start,
    $rose(frame_strobe_o) |-> cnt_q == '0,
    "frame started mid-count")

endmodule
